>>> src/frst_pkg.sv
// Package for the frame reassembly slot tracker.
// Holds the item kinds, result codes, sequencer states and configuration types.
// No dependencies.
package frst_pkg;

  localparam int KIND_W = 2;
  localparam int STATUS_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SIDX_W = 6;
  localparam int OFF_W = SIDX_W + 16;
  localparam logic [23:0] BYTES_MAX = 24'hFFFFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_PKT  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_SCAN = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_WRITTEN   = 4'd0,
    ST_COMPLETE  = 4'd1,
    ST_BAD_HDR   = 4'd2,
    ST_OVERSIZE  = 4'd3,
    ST_STALE     = 4'd4,
    ST_NO_BUF    = 4'd5,
    ST_BAD_SECT  = 4'd6,
    ST_DUPLICATE = 4'd7,
    ST_TICK      = 4'd8
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_PAYLOAD = 3'd0,
    REG_BIG_FRAME   = 3'd1,
    REG_SLOT_CAP    = 3'd2,
    REG_SYNC_TO     = 3'd3,
    REG_REASM_TO    = 3'd4,
    REG_MIN_DIFF    = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_CHECK,
    SEQ_SCAN,
    SEQ_FIND,
    SEQ_SEL,
    SEQ_RMW,
    SEQ_PUSH,
    SEQ_FINISH
  } seq_t;

  typedef struct packed {
    logic [15:0]        max_payload;
    logic [23:0]        big_frame;
    logic [23:0]        slot_cap;
    logic [31:0]        sync_to;
    logic [31:0]        reasm_to;
    logic signed [15:0] min_diff;
  } cfg_t;

endpackage

>>> src/frst_cfg_regs.sv
// Configuration registers of the frame reassembly slot tracker.
// Depends on frst_pkg.
module frst_cfg_regs
  import frst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_payload <= 16'd1024;
      cfg.big_frame   <= 24'd65536;
      cfg.slot_cap    <= 24'd1048576;
      cfg.sync_to     <= 32'd1000;
      cfg.reasm_to    <= 32'd200;
      cfg.min_diff    <= -16'sd100;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MAX_PAYLOAD: cfg.max_payload <= cfg_data[15:0];
        REG_BIG_FRAME:   cfg.big_frame <= cfg_data[23:0];
        REG_SLOT_CAP:    cfg.slot_cap <= cfg_data[23:0];
        REG_SYNC_TO:     cfg.sync_to <= cfg_data;
        REG_REASM_TO:    cfg.reasm_to <= cfg_data;
        REG_MIN_DIFF:    cfg.min_diff <= signed'(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

endmodule

>>> src/frst_slot_mem.sv
// Slot record memory: one write port, one read port, registered read data.
// No dependencies.
module frst_slot_mem #(
  parameter int DEPTH = 4,
  parameter int AW = 2,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/frame_reassembly_slot_tracker_top.sv
// Top level of the frame reassembly slot tracker: sequencer around the slot memory.
// Depends on frst_pkg, frst_cfg_regs and frst_slot_mem.
//
// Usage: items (packet headers, ticks, timeout scans) enter on the in_valid /
// in_ready channel, one word per item, and each item yields exactly one result
// word on the out_valid / out_ready channel. Configuration registers are
// written through cfg_we, cfg_index and cfg_data while the block is idle.
// The slot records live in a memory with registered read data; per-slot
// occupancy sits in flip-flops, so an empty slot needs no memory clearing.
// A scan walks the memory, one slot read per cycle. An accepted packet walks the
// memory to search for its slot, and a packet that completes a frame walks it
// again to clear older frames, one slot per cycle in each walk. A tick, an
// unknown kind or a packet dropped on its header checks reads no slot.
// One item is worked on at a time; the next is taken while the previous result
// still waits in the output register. When the receiver stalls, the result
// holds and a second finished result waits inside until the register frees.
// Reset (synchronous, active high) empties all slots, drops sync, zeroes time
// and loads the register defaults.
module frame_reassembly_slot_tracker_top
  import frst_pkg::*;
#(
  parameter int NUM_SLOTS = 4,
  parameter int MAX_SECTIONS = 64,
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            kind,
  input  logic                  header_valid,
  input  logic [15:0]           frame_index,
  input  logic [15:0]           section_index,
  input  logic [23:0]           frame_length,
  input  logic [15:0]           payload_len,
  input  logic                  buffer_free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            status,
  output logic [1:0]            slot,
  output logic [23:0]           write_offset,
  output logic [15:0]           write_len,
  output logic                  evicted,
  output logic                  sync_lost,
  output logic                  resynced,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNW = $clog2(NUM_SLOTS + 1);
  localparam int BMW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CMPW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int RW = 16 + 24 + TIME_BITS + MAX_SECTIONS + 24;

  cfg_t cfg;

  frst_cfg_regs u_cfg (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [RW-1:0] mem_wdata;
  logic [SW-1:0] mem_raddr;
  logic [RW-1:0] mem_rdata;

  frst_slot_mem #(.DEPTH(NUM_SLOTS), .AW(SW), .DW(RW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  logic [15:0]           rd_num;
  logic [23:0]           rd_bytes;
  logic [TIME_BITS-1:0]  rd_start;
  logic [MAX_SECTIONS-1:0] rd_bitmap;
  logic [23:0]           rd_got;

  assign {rd_num, rd_bytes, rd_start, rd_bitmap, rd_got} = mem_rdata;

  seq_t state, state_next;
  logic [NUM_SLOTS-1:0] occ, occ_next;
  logic synced, synced_next;
  logic [15:0] last_pushed, last_pushed_next;
  logic [TIME_BITS-1:0] last_act, last_act_next;
  logic [TIME_BITS-1:0] cur_time, cur_time_next;
  logic [CNW-1:0] cnt, cnt_next;

  logic k_hvalid;
  logic [15:0] k_fidx;
  logic [15:0] k_sidx;
  logic [23:0] k_flen;
  logic [15:0] k_plen;
  logic k_bfree;
  logic [OFF_W-1:0] k_off;

  logic m_hit, m_hit_next;
  logic [SW-1:0] m_idx, m_idx_next;
  logic e_have, e_have_next;
  logic [SW-1:0] e_idx, e_idx_next;
  logic s_have, s_have_next;
  logic [SW-1:0] s_idx, s_idx_next;
  logic [TIME_BITS-1:0] s_age, s_age_next;
  logic l_have, l_have_next;
  logic [SW-1:0] l_idx, l_idx_next;
  logic [TIME_BITS-1:0] l_age, l_age_next;
  logic [SW-1:0] sel, sel_next;

  status_t r_status, r_status_next;
  logic [SW-1:0] r_slot, r_slot_next;
  logic [23:0] r_woff, r_woff_next;
  logic [15:0] r_wlen, r_wlen_next;
  logic r_evict, r_evict_next;
  logic r_lost, r_lost_next;
  logic r_resync, r_resync_next;
  logic out_valid_next;
  logic load_out;

  logic [CNW-1:0] eval_cnt;
  logic [SW-1:0] e;
  logic [TIME_BITS-1:0] age_rd, age_act;
  logic aged;
  logic signed [15:0] d_pkt, d_push;
  logic [SW-1:0] pick;
  logic occ_s;
  logic [23:0] c_bytes, c_got, got_new;
  logic [MAX_SECTIONS-1:0] c_bitmap;
  logic [TIME_BITS-1:0] c_start;
  logic [24:0] got_sum;
  logic [23:0] end_off;
  logic [SW+1:0] slot_ext;

  assign eval_cnt = cnt - CNW'(1);
  assign e = eval_cnt[SW-1:0];
  assign age_rd = cur_time - rd_start;
  assign age_act = cur_time - last_act;
  assign aged = synced && (CMPW'(age_act) > CMPW'(cfg.sync_to));
  assign d_pkt = signed'(k_fidx - last_pushed);
  assign d_push = signed'(rd_num - k_fidx);
  assign pick = m_hit ? m_idx : e_have ? e_idx : s_have ? s_idx : l_idx;
  assign occ_s = occ[sel];
  assign c_bytes = occ_s ? rd_bytes : k_flen;
  assign c_got = occ_s ? rd_got : 24'd0;
  assign c_bitmap = occ_s ? rd_bitmap : '0;
  assign c_start = occ_s ? rd_start : cur_time;
  assign got_sum = {1'b0, c_got} + {9'd0, k_plen};
  assign got_new = got_sum[24] ? BYTES_MAX : got_sum[23:0];
  assign end_off = 24'({1'b0, k_off} + {7'd0, k_plen});
  assign in_ready = (state == SEQ_IDLE);
  assign slot_ext = {2'b00, r_slot};

  always_comb begin
    state_next = state;
    occ_next = occ;
    synced_next = synced;
    last_pushed_next = last_pushed;
    last_act_next = last_act;
    cur_time_next = cur_time;
    cnt_next = cnt;
    m_hit_next = m_hit;
    m_idx_next = m_idx;
    e_have_next = e_have;
    e_idx_next = e_idx;
    s_have_next = s_have;
    s_idx_next = s_idx;
    s_age_next = s_age;
    l_have_next = l_have;
    l_idx_next = l_idx;
    l_age_next = l_age;
    sel_next = sel;
    r_status_next = r_status;
    r_slot_next = r_slot;
    r_woff_next = r_woff;
    r_wlen_next = r_wlen;
    r_evict_next = r_evict;
    r_lost_next = r_lost;
    r_resync_next = r_resync;
    mem_we = 1'b0;
    mem_waddr = sel;
    mem_wdata = {k_fidx, c_bytes, c_start, c_bitmap, c_got};
    mem_raddr = (cnt < CNW'(NUM_SLOTS)) ? cnt[SW-1:0] : '0;
    load_out = 1'b0;
    out_valid_next = out_valid && !out_ready;

    case (state)
      SEQ_IDLE: begin
        if (in_valid) begin
          r_status_next = ST_TICK;
          r_slot_next = '0;
          r_woff_next = '0;
          r_wlen_next = '0;
          r_evict_next = 1'b0;
          r_lost_next = 1'b0;
          r_resync_next = 1'b0;
          cnt_next = '0;
          case (kind_t'(kind))
            KIND_TICK: begin
              cur_time_next = cur_time + TIME_BITS'(1);
              state_next = SEQ_FINISH;
            end
            KIND_SCAN: begin
              if (aged) begin
                synced_next = 1'b0;
                r_lost_next = 1'b1;
              end
              state_next = SEQ_SCAN;
            end
            KIND_PKT: state_next = SEQ_CHECK;
            default: state_next = SEQ_FINISH;
          endcase
        end
      end
      SEQ_CHECK: begin
        m_hit_next = 1'b0;
        e_have_next = 1'b0;
        s_have_next = 1'b0;
        l_have_next = 1'b0;
        r_lost_next = aged;
        synced_next = synced && !aged;
        state_next = SEQ_FINISH;
        if (!k_hvalid) begin
          r_status_next = ST_BAD_HDR;
        end else if (k_flen > cfg.slot_cap) begin
          r_status_next = ST_OVERSIZE;
        end else if (synced && !aged && d_pkt < cfg.min_diff) begin
          r_lost_next = 1'b1;
          synced_next = 1'b1;
          last_pushed_next = k_fidx - 16'd1;
          r_resync_next = 1'b1;
          last_act_next = cur_time;
          state_next = SEQ_FIND;
        end else if (synced && !aged && d_pkt <= 16'sd0) begin
          r_status_next = ST_STALE;
        end else begin
          if (!(synced && !aged)) begin
            synced_next = 1'b1;
            last_pushed_next = k_fidx - 16'd1;
            r_resync_next = 1'b1;
          end
          last_act_next = cur_time;
          state_next = SEQ_FIND;
        end
      end
      SEQ_SCAN: begin
        if (cnt != '0 && occ[e] && (CMPW'(age_rd) > CMPW'(cfg.reasm_to))) begin
          occ_next[e] = 1'b0;
        end
        if (cnt == CNW'(NUM_SLOTS)) begin
          state_next = SEQ_FINISH;
        end else begin
          cnt_next = cnt + CNW'(1);
        end
      end
      SEQ_FIND: begin
        if (cnt != '0 && !m_hit) begin
          if (occ[e] && rd_num == k_fidx) begin
            m_hit_next = 1'b1;
            m_idx_next = e;
          end else if (!occ[e]) begin
            if (!e_have) begin
              e_have_next = 1'b1;
              e_idx_next = e;
            end
          end else if (rd_bytes >= cfg.big_frame) begin
            if (!l_have || age_rd > l_age) begin
              l_have_next = 1'b1;
              l_idx_next = e;
              l_age_next = age_rd;
            end
          end else begin
            if (!s_have || age_rd > s_age) begin
              s_have_next = 1'b1;
              s_idx_next = e;
              s_age_next = age_rd;
            end
          end
        end
        if (cnt == CNW'(NUM_SLOTS)) begin
          state_next = SEQ_SEL;
        end else begin
          cnt_next = cnt + CNW'(1);
        end
      end
      SEQ_SEL: begin
        mem_raddr = pick;
        sel_next = pick;
        r_slot_next = pick;
        if (!m_hit && !e_have) begin
          occ_next[pick] = 1'b0;
          r_evict_next = 1'b1;
        end
        state_next = SEQ_RMW;
      end
      SEQ_RMW: begin
        state_next = SEQ_FINISH;
        cnt_next = '0;
        if (!occ_s && !k_bfree) begin
          r_status_next = ST_NO_BUF;
        end else begin
          occ_next[sel] = 1'b1;
          mem_we = 1'b1;
          if (c_got >= c_bytes) begin
            r_status_next = ST_DUPLICATE;
          end else if (k_sidx >= 16'(MAX_SECTIONS) || k_plen == 16'd0) begin
            r_status_next = ST_BAD_SECT;
          end else if (c_bitmap[k_sidx[BMW-1:0]]) begin
            r_status_next = ST_DUPLICATE;
          end else if (end_off > c_bytes) begin
            r_status_next = ST_BAD_SECT;
          end else begin
            mem_wdata = {k_fidx, c_bytes, c_start,
                         c_bitmap | (MAX_SECTIONS'(1) << k_sidx[BMW-1:0]), got_new};
            r_woff_next = 24'(k_off);
            r_wlen_next = k_plen;
            r_status_next = ST_WRITTEN;
            if (got_new >= c_bytes) begin
              r_status_next = ST_COMPLETE;
              mem_we = 1'b0;
              occ_next[sel] = 1'b0;
              last_pushed_next = k_fidx;
              state_next = SEQ_PUSH;
            end
          end
        end
      end
      SEQ_PUSH: begin
        if (cnt != '0 && occ[e] && (d_push < 16'sd0 || rd_num == k_fidx)) begin
          occ_next[e] = 1'b0;
        end
        if (cnt == CNW'(NUM_SLOTS)) begin
          state_next = SEQ_FINISH;
        end else begin
          cnt_next = cnt + CNW'(1);
        end
      end
      SEQ_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out = 1'b1;
          out_valid_next = 1'b1;
          state_next = SEQ_IDLE;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      occ <= '0;
      synced <= 1'b0;
      last_pushed <= '0;
      last_act <= '0;
      cur_time <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ <= occ_next;
      synced <= synced_next;
      last_pushed <= last_pushed_next;
      last_act <= last_act_next;
      cur_time <= cur_time_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    m_hit <= m_hit_next;
    m_idx <= m_idx_next;
    e_have <= e_have_next;
    e_idx <= e_idx_next;
    s_have <= s_have_next;
    s_idx <= s_idx_next;
    s_age <= s_age_next;
    l_have <= l_have_next;
    l_idx <= l_idx_next;
    l_age <= l_age_next;
    sel <= sel_next;
    r_status <= r_status_next;
    r_slot <= r_slot_next;
    r_woff <= r_woff_next;
    r_wlen <= r_wlen_next;
    r_evict <= r_evict_next;
    r_lost <= r_lost_next;
    r_resync <= r_resync_next;
    if (in_valid && in_ready) begin
      k_hvalid <= header_valid;
      k_fidx <= frame_index;
      k_sidx <= section_index;
      k_flen <= frame_length;
      k_plen <= payload_len;
      k_bfree <= buffer_free;
      k_off <= section_index[SIDX_W-1:0] * cfg.max_payload;
    end
    if (load_out) begin
      status <= r_status;
      slot <= slot_ext[1:0];
      write_offset <= r_woff;
      write_len <= r_wlen;
      evicted <= r_evict;
      sync_lost <= r_lost;
      resynced <= r_resync;
    end
  end

endmodule

>>> src/frst_checker.sv
// Port-level checks for the frame reassembly slot tracker, bound to the top level.
// Depends on frst_pkg and frame_reassembly_slot_tracker_top.
module frst_checker
  import frst_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] status,
  input logic [23:0] write_offset,
  input logic [15:0] write_len,
  input logic       resynced
);

  // One item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_TICK)
    else $error("result code out of range");

  a_write_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_WRITTEN && status != ST_COMPLETE
      |-> write_len == 16'd0 && write_offset == 24'd0)
    else $error("write descriptor on a rejected word");

  a_resync: assert property (@(posedge clk) disable iff (rst)
    out_valid && resynced
      |-> status != ST_BAD_HDR && status != ST_OVERSIZE && status != ST_STALE
          && status != ST_TICK)
    else $error("resync on a dropped word");

endmodule

bind frame_reassembly_slot_tracker_top frst_checker u_frst_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .write_offset(write_offset), .write_len(write_len), .resynced(resynced)
);

>>> dv/tb.sv
// Self-checking testbench for frame_reassembly_slot_tracker_top.
// A scoreboard class predicts one result word per accepted item and checks it in order.
// Depends on frst_pkg and the RTL of the slot tracker.
`timescale 1ns / 1ps

module tb;
  import frst_pkg::*;

  localparam int NSLOT = 4;
  localparam int NSECT = 64;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic [1:0]  kind;
    logic        hvalid;
    logic [15:0] fidx;
    logic [15:0] sidx;
    logic [23:0] flen;
    logic [15:0] plen;
    logic        bfree;
  } word_in_t;

  typedef struct {
    logic [3:0]  status;
    logic [1:0]  slot;
    logic [23:0] woff;
    logic [15:0] wlen;
    logic        evicted;
    logic        lost;
    logic        resync;
  } word_out_t;

  class reassembly_scoreboard;
    bit          occ[NSLOT];
    logic [15:0] num[NSLOT];
    logic [23:0] bytes[NSLOT];
    logic [31:0] start[NSLOT];
    logic [63:0] bitmap[NSLOT];
    logic [23:0] got[NSLOT];
    bit          synced;
    logic [15:0] last_pushed;
    logic [31:0] last_act;
    logic [31:0] now;
    cfg_t        cfg;
    word_out_t   pending[$];
    int          errors;
    int          checked;
    int          completes;
    int          evictions;

    function void reset_state();
      for (int i = 0; i < NSLOT; i++) clear(i);
      synced = 0;
      last_pushed = 0;
      last_act = 0;
      now = 0;
      cfg.max_payload = 1024;
      cfg.big_frame = 65536;
      cfg.slot_cap = 1048576;
      cfg.sync_to = 1000;
      cfg.reasm_to = 200;
      cfg.min_diff = -100;
    endfunction

    function void clear(int i);
      occ[i] = 0;
      num[i] = 0;
      bytes[i] = 0;
      start[i] = 0;
      bitmap[i] = 0;
      got[i] = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_MAX_PAYLOAD: cfg.max_payload = v[15:0];
        REG_BIG_FRAME: cfg.big_frame = v[23:0];
        REG_SLOT_CAP: cfg.slot_cap = v[23:0];
        REG_SYNC_TO: cfg.sync_to = v;
        REG_REASM_TO: cfg.reasm_to = v;
        REG_MIN_DIFF: cfg.min_diff = v[15:0];
        default: ;
      endcase
    endfunction

    function bit lose_sync();
      logic [31:0] age;
      age = now - last_act;
      if (synced && age > cfg.sync_to) begin
        synced = 0;
        return 1;
      end
      return 0;
    endfunction

    function void note_item(word_in_t w);
      word_out_t r;
      logic signed [15:0] d;
      int sel, fe, osm, olg;
      logic [31:0] asm, alg, age;
      logic [39:0] off;
      logic [24:0] sum;
      r = '{ST_TICK, 0, 0, 0, 0, 0, 0};
      if (w.kind == KIND_TICK) begin
        now++;
      end else if (w.kind == KIND_SCAN) begin
        r.lost = lose_sync();
        for (int i = 0; i < NSLOT; i++)
          if (occ[i] && (now - start[i]) > cfg.reasm_to) clear(i);
      end else if (w.kind == KIND_PKT) begin
        r.lost = lose_sync();
        sel = -1; fe = -1; osm = -1; olg = -1; asm = 0; alg = 0;
        if (!w.hvalid) r.status = ST_BAD_HDR;
        else if (w.flen > cfg.slot_cap) r.status = ST_OVERSIZE;
        else begin
          d = w.fidx - last_pushed;
          if (synced && d < cfg.min_diff) begin
            synced = 0;
            r.lost = 1;
          end
          if (synced && d <= 0) r.status = ST_STALE;
          else begin
            if (!synced) begin
              synced = 1;
              last_pushed = w.fidx - 16'd1;
              r.resync = 1;
            end
            last_act = now;
            for (int i = 0; i < NSLOT; i++) begin
              age = now - start[i];
              if (occ[i] && num[i] == w.fidx) begin
                sel = i;
                break;
              end
              if (!occ[i]) begin
                if (fe < 0) fe = i;
              end else if (bytes[i] >= cfg.big_frame) begin
                if (olg < 0 || age > alg) begin olg = i; alg = age; end
              end else if (osm < 0 || age > asm) begin
                osm = i;
                asm = age;
              end
            end
            if (sel < 0) begin
              if (fe >= 0) sel = fe;
              else begin
                sel = osm >= 0 ? osm : olg;
                clear(sel);
                r.evicted = 1;
                evictions++;
              end
            end
            r.slot = sel[1:0];
            r.status = ST_WRITTEN;
            if (!occ[sel]) begin
              if (!w.bfree) r.status = ST_NO_BUF;
              else begin
                clear(sel);
                occ[sel] = 1;
                bytes[sel] = w.flen;
                num[sel] = w.fidx;
                start[sel] = now;
              end
            end
            off = w.sidx * cfg.max_payload;
            if (r.status == ST_NO_BUF) ;
            else if (got[sel] >= bytes[sel]) r.status = ST_DUPLICATE;
            else if (w.sidx >= NSECT || w.plen == 0) r.status = ST_BAD_SECT;
            else if (bitmap[sel][w.sidx[5:0]]) r.status = ST_DUPLICATE;
            else if (off + w.plen > bytes[sel]) r.status = ST_BAD_SECT;
            else begin
              bitmap[sel][w.sidx[5:0]] = 1;
              sum = got[sel] + w.plen;
              got[sel] = sum[24] ? BYTES_MAX : sum[23:0];
              r.woff = off[23:0];
              r.wlen = w.plen;
              if (got[sel] >= bytes[sel]) begin
                r.status = ST_COMPLETE;
                completes++;
                last_pushed = w.fidx;
                for (int i = 0; i < NSLOT; i++) begin
                  d = num[i] - w.fidx;
                  if ((occ[i] && d < 0) || num[i] == w.fidx) clear(i);
                end
              end
            end
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(word_out_t a);
      word_out_t e;
      bit bad;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      bad = 0;
      if (a.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
        bad = 1;
      end
      if (a.slot !== e.slot) begin
        $display("%0t: slot expected %0d actual %0d", $time, e.slot, a.slot);
        bad = 1;
      end
      if (a.woff !== e.woff) begin
        $display("%0t: write_offset expected %0h actual %0h", $time, e.woff, a.woff);
        bad = 1;
      end
      if (a.wlen !== e.wlen) begin
        $display("%0t: write_len expected %0h actual %0h", $time, e.wlen, a.wlen);
        bad = 1;
      end
      if (a.evicted !== e.evicted) begin
        $display("%0t: evicted expected %0b actual %0b", $time, e.evicted, a.evicted);
        bad = 1;
      end
      if (a.lost !== e.lost) begin
        $display("%0t: sync_lost expected %0b actual %0b", $time, e.lost, a.lost);
        bad = 1;
      end
      if (a.resync !== e.resync) begin
        $display("%0t: resynced expected %0b actual %0b", $time, e.resync, a.resync);
        bad = 1;
      end
      if (bad) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready;
  logic [1:0] kind = 0;
  logic header_valid = 0, buffer_free = 0;
  logic [15:0] frame_index = 0, section_index = 0, payload_len = 0;
  logic [23:0] frame_length = 0;
  logic out_valid, out_ready = 0;
  logic [3:0] status;
  logic [1:0] slot;
  logic [23:0] write_offset;
  logic [15:0] write_len;
  logic evicted, sync_lost, resynced;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_DATA_W-1:0] cfg_data = 0;

  int send_idle = 0, recv_stall = 0, hold_off = 0;
  int cycles = 0;
  int items = 0;
  logic [15:0] cur_frame = 100;
  reassembly_scoreboard sb = new();

  frame_reassembly_slot_tracker_top dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{status, slot, write_offset, write_len, evicted, sync_lost, resynced});
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // The word stays valid after acceptance until the next send or drain decides.
  task automatic send(word_in_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    kind <= w.kind;
    header_valid <= w.hvalid;
    frame_index <= w.fidx;
    section_index <= w.sidx;
    frame_length <= w.flen;
    payload_len <= w.plen;
    buffer_free <= w.bfree;
    do @(posedge clk); while (!in_ready);
    sb.note_item(w);
    items++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_reg(reg_idx_t idx, logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
  endtask

  task automatic send_pkt(logic [15:0] f, logic [15:0] s, logic [23:0] l, logic [15:0] p,
                          logic hv = 1, logic bf = 1);
    send('{KIND_PKT, hv, f, s, l, p, bf});
  endtask

  task automatic send_other(logic [1:0] k, int n = 1);
    repeat (n) send('{k, 1'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
                      16'($urandom), 1'($urandom)});
  endtask

  // Mostly well-formed frames near the current index, with some noise mixed in.
  task automatic random_word();
    int r;
    logic [15:0] f, s, p;
    logic [23:0] l;
    int nsec;
    r = $urandom_range(99);
    if (r < 8) send_other(KIND_TICK, $urandom_range(1, 20));
    else if (r < 11) send_other(KIND_SCAN);
    else if (r < 13) send_other(2'd3);
    else if (r < 20) begin
      send('{KIND_PKT, 1'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
             16'($urandom), 1'($urandom)});
    end else begin
      f = 16'(cur_frame + $urandom_range(0, 5) - (($urandom_range(9) == 0) ? 300 : 2));
      nsec = $urandom_range(1, 6);
      p = sb.cfg.max_payload;
      l = 24'(nsec * p - $urandom_range(0, p - 1));
      s = 16'($urandom_range(0, nsec));
      if ($urandom_range(19) == 0) s = 16'($urandom_range(0, 65535));
      p = (s == 16'(nsec - 1)) ? 16'(l - s * p) : p;
      if ($urandom_range(15) == 0) p = 16'($urandom_range(0, 65535));
      send_pkt(f, s, l, p, 1'($urandom_range(30) != 0), 1'($urandom_range(9) != 0));
      if ($urandom_range(5) == 0) cur_frame++;
    end
  endtask

  task automatic full_frame(logic [15:0] f, int nsec, logic [15:0] p);
    for (int i = nsec - 1; i >= 0; i--) send_pkt(f, 16'(i), 24'(nsec * p), p);
  endtask

  initial begin
    sb.errors = 0;
    sb.reset_state();
    repeat (4) @(negedge clk);
    rst <= 0;
    set_reg(REG_MAX_PAYLOAD, 100);
    set_reg(REG_BIG_FRAME, 300);
    set_reg(REG_SLOT_CAP, 24'hFFFFFF);
    set_reg(REG_SYNC_TO, 50);
    set_reg(REG_REASM_TO, 20);
    set_reg(REG_MIN_DIFF, 16'hFF9C);

    // Directed: bad header, no buffer, sections, duplicate, completion, eviction.
    send_pkt(16'hFFFF, 0, 24'hFFFFFF, 16'hFFFF, 0, 1);
    send_pkt(10, 63, 24'hFFFFFF, 16'hFFFF, 1, 0);
    send_pkt(10, 0, 250, 100);
    send_pkt(10, 0, 250, 100);
    send_pkt(10, 64, 250, 100);
    send_pkt(10, 1, 250, 0);
    send_pkt(10, 2, 250, 100);
    send_pkt(11, 0, 600, 100);
    send_pkt(12, 0, 100, 50);
    send_pkt(13, 0, 400, 100);
    send_pkt(14, 0, 400, 100);
    send_pkt(15, 0, 100, 60, 1, 0);
    send_pkt(10, 2, 250, 50);
    send_pkt(5, 0, 100, 100);
    send_pkt(16'hFF00, 0, 100, 100);
    send_other(KIND_TICK, 60);
    send_other(KIND_SCAN);
    send_pkt(16'h0000, 0, 1, 1);
    send_other(2'd3);
    full_frame(16'h0002, 3, 16'hFFFF);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph == 1 || ph == 5) ? 66 : (ph == 3 ? 22 : 0);
      recv_stall = (ph == 2 || ph == 4) ? 66 : (ph == 3 ? 22 : 0);
      if (ph == 4) hold_off = 200;
      cur_frame = 16'($urandom);
      case (ph)
        1: begin
          set_reg(REG_MAX_PAYLOAD, 1);
          set_reg(REG_SYNC_TO, 0);
          set_reg(REG_MIN_DIFF, 16'h8000);
          set_reg(REG_BIG_FRAME, 0);
        end
        2: begin
          set_reg(REG_MAX_PAYLOAD, 16'hFFFF);
          set_reg(REG_SYNC_TO, 32'hFFFFFFFF);
          set_reg(REG_REASM_TO, 32'hFFFFFFFF);
          set_reg(REG_MIN_DIFF, 0);
          set_reg(REG_BIG_FRAME, 24'hFFFFFF);
        end
        3: begin
          set_reg(REG_MAX_PAYLOAD, 64);
          set_reg(REG_SLOT_CAP, 1);
          set_reg(REG_REASM_TO, 0);
        end
        4: begin
          set_reg(REG_SLOT_CAP, 5000);
          set_reg(REG_SYNC_TO, 200);
          set_reg(REG_REASM_TO, 40);
          set_reg(REG_BIG_FRAME, 200);
          set_reg(REG_MIN_DIFF, 16'hFFF0);
        end
        default: set_reg(REG_MAX_PAYLOAD, 128);
      endcase
      for (int n = 0; n < 160; n++) random_word();
      drain();
    end
    hold_off = 0;
    recv_stall = 0;
    drain();

    $display("Ran %0d items, %0d results checked, %0d frames completed, %0d evictions.",
             items, sb.checked, sb.completes, sb.evictions);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
src/frst_pkg.sv
src/frst_cfg_regs.sv
src/frst_slot_mem.sv
src/frame_reassembly_slot_tracker_top.sv
src/frst_checker.sv
dv/tb.sv
